// ===== hw/rtl/assert_macros.svh =====
// assertion helpers used by the checker file hbw_checker.sv
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// condition holds at every clock edge outside reset
`define CHK_ALWAYS(lbl, clk, rst, cond, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (cond)) else $error(msg);

// antecedent implies consequent in the same cycle
`define CHK_SAME(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// antecedent implies consequent in the next cycle
`define CHK_NEXT(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

// ===== hw/rtl/hbw_pkg.sv =====
package hbw_pkg;

   localparam int unsigned CHANNELS_DEF = 5;
   localparam int unsigned MASK_W       = 5;
   localparam int unsigned LIMIT_W      = 8;
   localparam int unsigned COUNT_W      = 9;
   localparam int unsigned CHAN_IDX_W   = 3;
   localparam int unsigned ADDR_W       = 3;
   localparam int unsigned DATA_W       = 32;
   localparam int unsigned REG_IDX_W    = 1;

   localparam logic [COUNT_W-1:0]    COUNT_MAX        = 9'd511;
   localparam logic [CHAN_IDX_W-1:0] NO_FAILURE       = 3'd7;
   localparam logic [LIMIT_W-1:0]    MISS_LIMIT_RESET = 8'd10;
   localparam logic [MASK_W-1:0]     CRITICAL_RESET   = 5'd7;

   localparam logic [REG_IDX_W-1:0] REG_MISS_LIMIT    = 1'b0;
   localparam logic [REG_IDX_W-1:0] REG_CRITICAL_MASK = 1'b1;

   typedef struct packed {
      logic [LIMIT_W-1:0] miss_limit;
      logic [MASK_W-1:0]  critical_mask;
   } cfg_type;

   typedef struct packed {
      logic [MASK_W-1:0]     clear_mask;
      logic [MASK_W-1:0]     restart_mask;
      logic [MASK_W-1:0]     kill_mask;
      logic                  shutdown;
      logic [CHAN_IDX_W-1:0] failed_channel;
   } result_type;

endpackage

// ===== hw/rtl/hbw_csr.sv =====
module hbw_csr (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          psel,
   input  logic                          penable,
   input  logic                          pwrite,
   input  logic [hbw_pkg::ADDR_W-1:0]    paddr,
   input  logic [hbw_pkg::DATA_W-1:0]    pwdata,
   output logic [hbw_pkg::DATA_W-1:0]    prdata,
   output logic                          pready,
   output hbw_pkg::cfg_type              cfg
);
   import hbw_pkg::*;

   logic [LIMIT_W-1:0]   miss_limit_ff;
   logic [LIMIT_W-1:0]   miss_limit_in;
   logic [MASK_W-1:0]    critical_ff;
   logic [MASK_W-1:0]    critical_in;
   logic [REG_IDX_W-1:0] reg_idx;
   logic                 wr_en;

   assign pready  = 1'b1;
   assign reg_idx = paddr[ADDR_W-1:2];
   assign wr_en   = psel && penable && pwrite && pready;

   always_comb begin
      miss_limit_in = miss_limit_ff;
      critical_in   = critical_ff;
      if (wr_en) begin
         case (reg_idx)
            REG_MISS_LIMIT: begin
               miss_limit_in = pwdata[LIMIT_W-1:0];
            end
            REG_CRITICAL_MASK: begin
               critical_in = pwdata[MASK_W-1:0];
            end
            default: begin
               miss_limit_in = miss_limit_ff;
            end
         endcase
      end
   end

   always_comb begin
      case (reg_idx)
         REG_MISS_LIMIT: begin
            prdata = DATA_W'(miss_limit_ff);
         end
         REG_CRITICAL_MASK: begin
            prdata = DATA_W'(critical_ff);
         end
         default: begin
            prdata = '0;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         miss_limit_ff <= MISS_LIMIT_RESET;
         critical_ff   <= CRITICAL_RESET;
      end else begin
         miss_limit_ff <= miss_limit_in;
         critical_ff   <= critical_in;
      end
   end

   assign cfg.miss_limit    = miss_limit_ff;
   assign cfg.critical_mask = critical_ff;

endmodule

// ===== hw/rtl/hbw_eval.sv =====
module hbw_eval #(
   parameter int unsigned CHANNELS = hbw_pkg::CHANNELS_DEF
) (
   input  logic [hbw_pkg::MASK_W-1:0]                   heartbeat_flags,
   input  logic [hbw_pkg::MASK_W-1:0]                   exited_flags,
   input  logic                                         shutdown_request,
   input  logic                                         halted,
   input  hbw_pkg::cfg_type                             cfg,
   input  logic [CHANNELS-1:0][hbw_pkg::COUNT_W-1:0]    count,
   output logic [CHANNELS-1:0][hbw_pkg::COUNT_W-1:0]    count_next,
   output hbw_pkg::result_type                          result
);
   import hbw_pkg::*;

   localparam int unsigned XW = (CHANNELS > MASK_W) ? CHANNELS : MASK_W;

   logic [XW-1:0]         hb_x;
   logic [XW-1:0]         ex_x;
   logic [XW-1:0]         crit_x;
   logic [XW-1:0]         clr_x;
   logic [XW-1:0]         rst_x;
   logic [XW-1:0]         kill_x;
   logic [COUNT_W-1:0]    inc;
   logic [CHAN_IDX_W-1:0] failed;
   logic                  blocked;
   logic                  stop;

   assign hb_x    = XW'(heartbeat_flags);
   assign ex_x    = XW'(exited_flags);
   assign crit_x  = XW'(cfg.critical_mask);
   assign blocked = halted || shutdown_request;

   // channels in index order, a critical failure ends the pass; none is visited while halted or on a shutdown request
   always_comb begin
      stop       = 1'b0;
      clr_x      = '0;
      rst_x      = '0;
      kill_x     = '0;
      failed     = NO_FAILURE;
      count_next = count;
      inc        = '0;
      for (int i = 0; i < CHANNELS; i++) begin
         inc = (count[i] == COUNT_MAX) ? count[i] : count[i] + 1'b1;
         if (!blocked && !stop) begin
            if (hb_x[i]) begin
               clr_x[i]      = 1'b1;
               count_next[i] = '0;
            end else if (inc > COUNT_W'(cfg.miss_limit)) begin
               if (crit_x[i]) begin
                  stop          = 1'b1;
                  failed        = CHAN_IDX_W'(i);
                  count_next[i] = inc;
               end else begin
                  rst_x[i]      = 1'b1;
                  kill_x[i]     = !ex_x[i];
                  count_next[i] = '0;
               end
            end else begin
               count_next[i] = inc;
            end
         end
      end
   end

   assign result.clear_mask     = clr_x[MASK_W-1:0];
   assign result.restart_mask   = rst_x[MASK_W-1:0];
   assign result.kill_mask      = kill_x[MASK_W-1:0];
   assign result.shutdown       = blocked || stop;
   assign result.failed_channel = failed;

endmodule

// ===== hw/rtl/heartbeat_watchdog_multi.sv =====
// Multi-channel heartbeat watchdog. Each req_ transfer is one supervision tick;
// each tick yields exactly one rsp_ transfer with the clear, restart and kill
// masks, the shutdown flag and the index of the critical channel that failed
// (7 when none did). One tick is taken every clock cycle while req_ does not
// stall; a tick passes an input register, the channel evaluation logic and a
// result register, from which its result is offered. A stalled result holds the
// next tick in the input register, and req_ stalls until the result moves on.
// Per-channel miss counters and the halt flag update as a tick moves into the
// result register. Once halted, the block reports shutdown on every tick until
// reset. The user writes miss_limit (address 0) and critical_mask (address 4)
// through the APB port only while no tick is in flight; it is not enforced.
module heartbeat_watchdog_multi #(
   parameter int unsigned CHANNELS = hbw_pkg::CHANNELS_DEF
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_valid,
   output logic                              req_stall,
   input  logic [hbw_pkg::MASK_W-1:0]        req_heartbeat_flags,
   input  logic [hbw_pkg::MASK_W-1:0]        req_exited_flags,
   input  logic                              req_shutdown_request,
   output logic                              rsp_valid,
   input  logic                              rsp_stall,
   output logic [hbw_pkg::MASK_W-1:0]        rsp_clear_mask,
   output logic [hbw_pkg::MASK_W-1:0]        rsp_restart_mask,
   output logic [hbw_pkg::MASK_W-1:0]        rsp_kill_mask,
   output logic                              rsp_shutdown,
   output logic [hbw_pkg::CHAN_IDX_W-1:0]    rsp_failed_channel,
   input  logic                              psel,
   input  logic                              penable,
   input  logic                              pwrite,
   input  logic [hbw_pkg::ADDR_W-1:0]        paddr,
   input  logic [hbw_pkg::DATA_W-1:0]        pwdata,
   output logic [hbw_pkg::DATA_W-1:0]        prdata,
   output logic                              pready
);
   import hbw_pkg::*;

   cfg_type                           cfg;
   result_type                        result;
   result_type                        out_ff;
   logic [CHANNELS-1:0][COUNT_W-1:0]  count_ff;
   logic [CHANNELS-1:0][COUNT_W-1:0]  count_in;
   logic                              halted_ff;
   logic                              in_valid_ff;
   logic                              in_valid_in;
   logic                              out_valid_ff;
   logic                              out_valid_in;
   logic [MASK_W-1:0]                 hb_ff;
   logic [MASK_W-1:0]                 ex_ff;
   logic                              sreq_ff;
   logic                              advance;

   hbw_csr u_csr (
      .clock   (clock),
      .reset   (reset),
      .psel    (psel),
      .penable (penable),
      .pwrite  (pwrite),
      .paddr   (paddr),
      .pwdata  (pwdata),
      .prdata  (prdata),
      .pready  (pready),
      .cfg     (cfg)
   );

   hbw_eval #(
      .CHANNELS (CHANNELS)
   ) u_eval (
      .heartbeat_flags  (hb_ff),
      .exited_flags     (ex_ff),
      .shutdown_request (sreq_ff),
      .halted           (halted_ff),
      .cfg              (cfg),
      .count            (count_ff),
      .count_next       (count_in),
      .result           (result)
   );

   assign advance      = in_valid_ff && (!out_valid_ff || !rsp_stall);
   assign req_stall    = in_valid_ff && !advance;
   assign in_valid_in  = req_stall ? 1'b1 : req_valid;
   assign out_valid_in = advance || (out_valid_ff && rsp_stall);

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
         halted_ff    <= 1'b0;
         count_ff     <= '0;
      end else begin
         in_valid_ff  <= in_valid_in;
         out_valid_ff <= out_valid_in;
         if (advance) begin
            halted_ff <= result.shutdown;
            count_ff  <= count_in;
         end
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      if (req_valid && !req_stall) begin
         hb_ff   <= req_heartbeat_flags;
         ex_ff   <= req_exited_flags;
         sreq_ff <= req_shutdown_request;
      end
      if (advance) begin
         out_ff <= result;
      end
   end

   assign rsp_valid          = out_valid_ff;
   assign rsp_clear_mask     = out_ff.clear_mask;
   assign rsp_restart_mask   = out_ff.restart_mask;
   assign rsp_kill_mask      = out_ff.kill_mask;
   assign rsp_shutdown       = out_ff.shutdown;
   assign rsp_failed_channel = out_ff.failed_channel;

endmodule

// ===== hw/rtl/hbw_checker.sv =====
`include "assert_macros.svh"

module hbw_checker (
   input logic                              clock,
   input logic                              reset,
   input logic                              rsp_valid,
   input logic                              rsp_stall,
   input logic [hbw_pkg::MASK_W-1:0]        rsp_clear_mask,
   input logic [hbw_pkg::MASK_W-1:0]        rsp_restart_mask,
   input logic [hbw_pkg::MASK_W-1:0]        rsp_kill_mask,
   input logic                              rsp_shutdown,
   input logic [hbw_pkg::CHAN_IDX_W-1:0]    rsp_failed_channel
);
   import hbw_pkg::*;

   // every killed channel is also restarted
   `CHK_SAME(a_kill_in_restart, clock, reset, rsp_valid, (rsp_kill_mask & ~rsp_restart_mask) == '0, "kill outside restart")

   // a channel with a heartbeat is never restarted on the same tick
   `CHK_SAME(a_clear_no_restart, clock, reset, rsp_valid, (rsp_clear_mask & rsp_restart_mask) == '0, "cleared channel restarted")

   // a failed channel index only comes with shutdown
   `CHK_SAME(a_fail_shutdown, clock, reset, rsp_valid && (rsp_failed_channel != NO_FAILURE), rsp_shutdown, "failure without shutdown")

   // shutdown with no failing channel means no channel was visited
   `CHK_SAME(a_halt_quiet, clock, reset, rsp_valid && rsp_shutdown && (rsp_failed_channel == NO_FAILURE), (rsp_clear_mask | rsp_restart_mask | rsp_kill_mask) == '0, "activity while halted")

   // a stalled result transfer holds its restart mask and failed channel index
   `CHK_NEXT(a_rsp_hold, clock, reset, rsp_valid && rsp_stall, rsp_valid && $stable(rsp_restart_mask) && $stable(rsp_failed_channel), "stalled result changed")

endmodule

bind heartbeat_watchdog_multi hbw_checker u_hbw_checker (
   .clock              (clock),
   .reset              (reset),
   .rsp_valid          (rsp_valid),
   .rsp_stall          (rsp_stall),
   .rsp_clear_mask     (rsp_clear_mask),
   .rsp_restart_mask   (rsp_restart_mask),
   .rsp_kill_mask      (rsp_kill_mask),
   .rsp_shutdown       (rsp_shutdown),
   .rsp_failed_channel (rsp_failed_channel)
);

// ===== verif/heartbeat_watchdog_multi_checker.sv =====
`timescale 1ns / 100ps

module heartbeat_watchdog_multi_checker #(
   parameter int unsigned CHANNELS = hbw_pkg::CHANNELS_DEF
) (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           req_valid,
   input  logic                           req_stall,
   input  logic [hbw_pkg::MASK_W-1:0]     req_heartbeat_flags,
   input  logic [hbw_pkg::MASK_W-1:0]     req_exited_flags,
   input  logic                           req_shutdown_request,
   input  logic                           rsp_valid,
   input  logic                           rsp_stall,
   input  logic [hbw_pkg::MASK_W-1:0]     rsp_clear_mask,
   input  logic [hbw_pkg::MASK_W-1:0]     rsp_restart_mask,
   input  logic [hbw_pkg::MASK_W-1:0]     rsp_kill_mask,
   input  logic                           rsp_shutdown,
   input  logic [hbw_pkg::CHAN_IDX_W-1:0] rsp_failed_channel,
   input  logic                           psel,
   input  logic                           penable,
   input  logic                           pwrite,
   input  logic [hbw_pkg::ADDR_W-1:0]     paddr,
   input  logic [hbw_pkg::DATA_W-1:0]     pwdata,
   input  logic                           pready,
   output int unsigned                    errors,
   output int unsigned                    outstanding
);
   import hbw_pkg::*;

   logic [COUNT_W-1:0]   miss_cnt [CHANNELS];
   logic                 halted_q;
   logic [LIMIT_W-1:0]   limit_q;
   logic [MASK_W-1:0]    crit_q;
   logic [REG_IDX_W-1:0] reg_idx;
   result_type           pending_ticks [$];
   result_type           want;
   result_type           got;

   assign outstanding = pending_ticks.size();

   task automatic supervise_tick(input logic [MASK_W-1:0] hb, input logic [MASK_W-1:0] ex,
                                 input logic req, output result_type res);
      logic stop;
      logic hb_bit;
      logic ex_bit;
      logic crit_bit;
      res = '0;
      res.failed_channel = NO_FAILURE;
      stop = 1'b0;
      if (!halted_q && req) begin
         halted_q = 1'b1;
      end
      if (!halted_q) begin
         for (int i = 0; i < CHANNELS; i++) begin
            if (!stop) begin
               hb_bit   = (i < MASK_W) ? hb[i] : 1'b0;
               ex_bit   = (i < MASK_W) ? ex[i] : 1'b0;
               crit_bit = (i < MASK_W) ? crit_q[i] : 1'b0;
               if (hb_bit) begin
                  if (i < MASK_W) res.clear_mask[i] = 1'b1;
                  miss_cnt[i] = '0;
               end else begin
                  if (miss_cnt[i] < COUNT_MAX) miss_cnt[i] = miss_cnt[i] + 1'b1;
                  if (miss_cnt[i] > {1'b0, limit_q}) begin
                     if (crit_bit) begin
                        halted_q = 1'b1;
                        res.failed_channel = CHAN_IDX_W'(i);
                        stop = 1'b1;
                     end else begin
                        if (i < MASK_W) begin
                           res.restart_mask[i] = 1'b1;
                           if (!ex_bit) res.kill_mask[i] = 1'b1;
                        end
                        miss_cnt[i] = '0;
                     end
                  end
               end
            end
         end
      end
      res.shutdown = halted_q;
   endtask

   always @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < CHANNELS; i++) miss_cnt[i] = '0;
         halted_q = 1'b0;
         limit_q = MISS_LIMIT_RESET;
         crit_q = CRITICAL_RESET;
         pending_ticks.delete();
      end else begin
         if (psel && penable && pwrite && pready) begin
            reg_idx = paddr[2 +: REG_IDX_W];
            if (reg_idx == REG_MISS_LIMIT) limit_q = pwdata[LIMIT_W-1:0];
            else if (reg_idx == REG_CRITICAL_MASK) crit_q = pwdata[MASK_W-1:0];
         end
         if (req_valid && !req_stall) begin
            supervise_tick(req_heartbeat_flags, req_exited_flags, req_shutdown_request, want);
            pending_ticks.push_back(want);
         end
         if (rsp_valid && !rsp_stall) begin
            got.clear_mask     = rsp_clear_mask;
            got.restart_mask   = rsp_restart_mask;
            got.kill_mask      = rsp_kill_mask;
            got.shutdown       = rsp_shutdown;
            got.failed_channel = rsp_failed_channel;
            if (pending_ticks.size() == 0) begin
               if (errors < 10)
                  $display("%0t unexpected transfer: clear=%h restart=%h kill=%h shut=%b fail=%0d",
                           $realtime, got.clear_mask, got.restart_mask, got.kill_mask,
                           got.shutdown, got.failed_channel);
               errors++;
            end else begin
               want = pending_ticks.pop_front();
               if (got !== want) begin
                  if (errors < 10)
                     $display("%0t mismatch: exp clear=%h restart=%h kill=%h shut=%b fail=%0d %s",
                              $realtime, want.clear_mask, want.restart_mask, want.kill_mask,
                              want.shutdown, want.failed_channel,
                              $sformatf("got clear=%h restart=%h kill=%h shut=%b fail=%0d",
                                        got.clear_mask, got.restart_mask, got.kill_mask,
                                        got.shutdown, got.failed_channel));
                  errors++;
               end
            end
         end
      end
   end

endmodule

// ===== verif/heartbeat_watchdog_multi_tb.sv =====
`timescale 1ns / 100ps

module heartbeat_watchdog_multi_tb;
   import hbw_pkg::*;

   logic                  clock = 1'b0;
   logic                  reset = 1'b1;
   logic                  req_valid = 1'b0;
   logic                  req_stall;
   logic [MASK_W-1:0]     req_heartbeat_flags = '0;
   logic [MASK_W-1:0]     req_exited_flags = '0;
   logic                  req_shutdown_request = 1'b0;
   logic                  rsp_valid;
   logic                  rsp_stall = 1'b0;
   logic [MASK_W-1:0]     rsp_clear_mask;
   logic [MASK_W-1:0]     rsp_restart_mask;
   logic [MASK_W-1:0]     rsp_kill_mask;
   logic                  rsp_shutdown;
   logic [CHAN_IDX_W-1:0] rsp_failed_channel;
   logic                  psel = 1'b0;
   logic                  penable = 1'b0;
   logic                  pwrite = 1'b0;
   logic [ADDR_W-1:0]     paddr = '0;
   logic [DATA_W-1:0]     pwdata = '0;
   logic [DATA_W-1:0]     prdata;
   logic                  pready;

   int unsigned errors;
   int unsigned outstanding;

   // stimulus-side view of the config and of the miss runs, to keep critical channels alive
   logic [LIMIT_W-1:0] cur_limit = MISS_LIMIT_RESET;
   logic [MASK_W-1:0]  cur_crit = CRITICAL_RESET;
   int                 miss_run [MASK_W];
   logic               guard_on = 1'b1;
   logic               tx_calm = 1'b0;
   logic               rx_calm = 1'b0;
   int                 rx_hold = 0;

   heartbeat_watchdog_multi u_dut (
      .clock                (clock),
      .reset                (reset),
      .req_valid            (req_valid),
      .req_stall            (req_stall),
      .req_heartbeat_flags  (req_heartbeat_flags),
      .req_exited_flags     (req_exited_flags),
      .req_shutdown_request (req_shutdown_request),
      .rsp_valid            (rsp_valid),
      .rsp_stall            (rsp_stall),
      .rsp_clear_mask       (rsp_clear_mask),
      .rsp_restart_mask     (rsp_restart_mask),
      .rsp_kill_mask        (rsp_kill_mask),
      .rsp_shutdown         (rsp_shutdown),
      .rsp_failed_channel   (rsp_failed_channel),
      .psel                 (psel),
      .penable              (penable),
      .pwrite               (pwrite),
      .paddr                (paddr),
      .pwdata               (pwdata),
      .prdata               (prdata),
      .pready               (pready)
   );

   heartbeat_watchdog_multi_checker u_checker (
      .clock                (clock),
      .reset                (reset),
      .req_valid            (req_valid),
      .req_stall            (req_stall),
      .req_heartbeat_flags  (req_heartbeat_flags),
      .req_exited_flags     (req_exited_flags),
      .req_shutdown_request (req_shutdown_request),
      .rsp_valid            (rsp_valid),
      .rsp_stall            (rsp_stall),
      .rsp_clear_mask       (rsp_clear_mask),
      .rsp_restart_mask     (rsp_restart_mask),
      .rsp_kill_mask        (rsp_kill_mask),
      .rsp_shutdown         (rsp_shutdown),
      .rsp_failed_channel   (rsp_failed_channel),
      .psel                 (psel),
      .penable              (penable),
      .pwrite               (pwrite),
      .paddr                (paddr),
      .pwdata               (pwdata),
      .pready               (pready),
      .errors               (errors),
      .outstanding          (outstanding)
   );

   initial begin
      forever #1 clock = ~clock;
   end

   initial begin
      #400000;
      $display("[FAIL] regression broken");
      $finish;
   end

   // result side: random wait after every transfer, none during calm stretches
   always @(posedge clock) begin
      if (reset) begin
         rx_hold = 0;
         rsp_stall <= 1'b0;
      end else begin
         if (rsp_valid && !rsp_stall) begin
            rx_hold = rx_calm ? 0 : $urandom_range(0, 10);
            if ($urandom_range(0, 39) == 0) rx_calm = !rx_calm;
         end else if (rx_hold > 0) begin
            rx_hold--;
         end
         rsp_stall <= (rx_hold > 0);
      end
   end

   task automatic send_tick(input logic [MASK_W-1:0] hb, input logic [MASK_W-1:0] ex,
                            input logic req);
      logic [MASK_W-1:0] hb_use;
      int                gap;
      hb_use = hb;
      if (guard_on) begin
         for (int i = 0; i < MASK_W; i++) begin
            if (cur_crit[i] && !hb_use[i] && miss_run[i] >= int'(cur_limit)) hb_use[i] = 1'b1;
            if (hb_use[i]) begin
               miss_run[i] = 0;
            end else begin
               miss_run[i]++;
               if (miss_run[i] > int'(cur_limit)) miss_run[i] = 0;
            end
         end
      end
      gap = tx_calm ? 0 : $urandom_range(0, 10);
      if ($urandom_range(0, 39) == 0) tx_calm = !tx_calm;
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid            <= 1'b1;
      req_heartbeat_flags  <= hb_use;
      req_exited_flags     <= ex;
      req_shutdown_request <= req;
      do @(posedge clock); while (req_stall);
   endtask

   task automatic rand_tick(input int density, input logic req);
      logic [MASK_W-1:0] hb;
      for (int i = 0; i < MASK_W; i++) hb[i] = ($urandom_range(0, 99) < density);
      send_tick(hb, MASK_W'($urandom_range(0, 31)), req);
   endtask

   // pause until every result is back, then let the pipeline drain
   task automatic settle();
      req_valid <= 1'b0;
      @(posedge clock);
      while (outstanding != 0) @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   task automatic write_reg(input logic [REG_IDX_W-1:0] idx, input logic [7:0] value);
      psel    <= 1'b1;
      penable <= 1'b0;
      pwrite  <= 1'b1;
      paddr   <= ADDR_W'({idx, 2'b00});
      pwdata  <= {24'($urandom), value};
      if (idx == REG_MISS_LIMIT) cur_limit = value;
      else cur_crit = value[MASK_W-1:0];
      @(posedge clock);
      penable <= 1'b1;
      do @(posedge clock); while (!pready);
      psel    <= 1'b0;
      penable <= 1'b0;
      pwrite  <= 1'b0;
      @(posedge clock);
   endtask

   initial begin
      logic [7:0]        lims [8];
      logic [7:0]        crits [8];
      logic [MASK_W-1:0] hb;
      int                density;
      int                chan;
      int                lim;

      lims  = '{8'd0, 8'd255, 8'd3, 8'd1, 8'd255, 8'd0, 8'd0, 8'd0};
      crits = '{8'd0, 8'd31, 8'd21, 8'd0, 8'd0, 8'd0, 8'd31, 8'd0};
      for (int i = 0; i < MASK_W; i++) miss_run[i] = 0;
      repeat (3) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // reset config
      send_tick(5'b11111, 5'b11111, 1'b0);
      send_tick(5'b00000, 5'b00000, 1'b0);
      send_tick(5'b01010, 5'b10101, 1'b0);
      // zero limit, nothing critical: every miss restarts
      settle();
      write_reg(REG_MISS_LIMIT, 8'd0);
      write_reg(REG_CRITICAL_MASK, 8'd0);
      send_tick(5'b00000, 5'b00000, 1'b0);
      send_tick(5'b00000, 5'b11111, 1'b0);
      send_tick(5'b11111, 5'b00000, 1'b0);
      send_tick(5'b10101, 5'b01010, 1'b0);
      send_tick(5'b01010, 5'b01010, 1'b0);
      // everything critical
      settle();
      write_reg(REG_CRITICAL_MASK, 8'd31);
      send_tick(5'b00000, 5'b00000, 1'b0);
      send_tick(5'b00000, 5'b11111, 1'b0);
      settle();
      write_reg(REG_MISS_LIMIT, 8'd255);
      send_tick(5'b00000, 5'b00000, 1'b0);
      send_tick(5'b00000, 5'b10101, 1'b0);
      send_tick(5'b11111, 5'b11111, 1'b0);
      settle();
      write_reg(REG_MISS_LIMIT, 8'd1);
      write_reg(REG_CRITICAL_MASK, 8'd18);
      send_tick(5'b00000, 5'b00000, 1'b0);
      send_tick(5'b00000, 5'b00101, 1'b0);
      send_tick(5'b00000, 5'b11010, 1'b0);
      send_tick(5'b10010, 5'b00101, 1'b0);

      for (int p = 0; p < 8; p++) begin
         if (p == 5) begin
            lims[p]  = 8'($urandom_range(0, 20));
            crits[p] = 8'($urandom_range(0, 31));
         end
         if (p == 7) begin
            lims[p]  = 8'($urandom_range(2, 8));
            crits[p] = 8'($urandom_range(0, 31));
         end
         settle();
         write_reg(REG_MISS_LIMIT, lims[p]);
         write_reg(REG_CRITICAL_MASK, crits[p]);
         density = 50;
         for (int n = 0; n < 60; n++) begin
            if (n % 20 == 0) density = $urandom_range(0, 100);
            rand_tick(density, 1'b0);
         end
      end

      // the block halts once, so one way into shutdown per run
      settle();
      if ($urandom_range(0, 1) == 1) begin
         chan = $urandom_range(0, 3);
         lim  = $urandom_range(0, 3);
         write_reg(REG_MISS_LIMIT, 8'(lim));
         write_reg(REG_CRITICAL_MASK, 8'(1 << chan));
         guard_on = 1'b0;
         repeat (lim + 2) begin
            hb = MASK_W'($urandom_range(0, 31));
            hb[chan] = 1'b0;
            send_tick(hb, MASK_W'($urandom_range(0, 31)), 1'b0);
         end
      end else begin
         repeat (5) rand_tick(50, 1'b0);
         guard_on = 1'b0;
         send_tick(MASK_W'($urandom_range(0, 31)), MASK_W'($urandom_range(0, 31)), 1'b1);
      end
      guard_on = 1'b0;
      repeat (20) begin
         rand_tick(50, 1'($urandom_range(0, 1)));
      end
      settle();
      repeat (6) @(posedge clock);

      if (errors == 0 && outstanding == 0) begin
         $display("[ OK ] regression clean");
      end else begin
         $display("[FAIL] regression broken");
      end
      $finish;
   end

endmodule
